>>> rtl/cpu_range_list_parser_defines.svh
// Assertion macros shared by the parser modules.
`ifndef CPU_RANGE_LIST_PARSER_DEFINES_SVH
`define CPU_RANGE_LIST_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define CRLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CRLP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRLP_ASSERT(label, clk, rst, prop, msg)
`define CRLP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/crlp_pkg.sv
package crlp_pkg;

   localparam int CHAR_W      = 8;
   localparam int NUM_W       = 7;
   localparam int MASK_W      = 64;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int DEF_ENTRIES = 64;

   localparam logic [NUM_W-1:0]  ENTRY_COUNT_RST = 7'd64;
   localparam logic [NUM_W-1:0]  NUM_SAT         = 7'd127;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

   localparam logic REG_ENTRY_COUNT = 1'b0;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_LOW   = 2'd1,
      PH_DASH  = 2'd2,
      PH_HIGH  = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              is_last;
   } step_type;

   typedef struct packed {
      logic              list_ok;
      logic [MASK_W-1:0] entry_mask;
   } result_type;

   function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                  input logic [3:0] d);
      logic [10:0] v;
      v = 11'(acc) * 11'd10 + 11'(d);
      return (v > 11'(NUM_SAT)) ? NUM_SAT : v[NUM_W-1:0];
   endfunction

endpackage

>>> rtl/crlp_csr.sv
module crlp_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crlp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [crlp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [crlp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output logic [crlp_pkg::NUM_W-1:0]        entry_count
);
   import crlp_pkg::*;

   logic [NUM_W-1:0] entry_count_ff;
   logic [NUM_W-1:0] entry_count_in;
   logic             wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (wr_en && (csr_paddr[CSR_ADDR_W-1] == REG_ENTRY_COUNT)) begin
         entry_count_in = csr_pwdata[NUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ENTRY_COUNT_RST;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[CSR_ADDR_W-1])
         REG_ENTRY_COUNT: csr_prdata = CSR_DATA_W'(entry_count_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign entry_count = entry_count_ff;

endmodule

>>> rtl/crlp_parse.sv
`include "cpu_range_list_parser_defines.svh"

module crlp_parse #(
   parameter int MAX_ENTRIES = crlp_pkg::DEF_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  crlp_pkg::step_type         step_data,
   input  logic [crlp_pkg::NUM_W-1:0] entry_count,
   output crlp_pkg::result_type       result
);
   import crlp_pkg::*;

   localparam logic [NUM_W-1:0] MAX_LIM = NUM_W'(MAX_ENTRIES);

   phase_type                phase_ff, phase_in, t_phase, ph_a;
   logic [NUM_W-1:0]         first_ff, first_in, second_ff, second_in;
   logic                     err_ff, err_in;
   logic [MAX_ENTRIES-1:0]   mask_ff, mask_in;

   logic [CHAR_W-1:0]        ch;
   logic                     is_digit, is_dash, is_comma, last;
   logic [3:0]               d;
   logic [NUM_W-1:0]         t_first, t_second, lim, lo, hi;
   logic                     char_err, commit_req, commit_bad, single, end_err, err_total;
   logic [MAX_ENTRIES-1:0]   ones, span, mask_total;
   logic [NUM_W:0]           hi_p1;

   assign ch       = step_data.char_in;
   assign last     = step_data.is_last;
   assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_dash  = (ch == CH_DASH);
   assign is_comma = (ch == CH_COMMA);
   assign d        = 4'(ch - CH_ZERO);
   assign lim      = (entry_count > MAX_LIM) ? MAX_LIM : entry_count;

   // Phase transitions caused by the character itself.
   always_comb begin
      t_phase  = phase_ff;
      ph_a     = phase_ff;
      char_err = 1'b0;
      unique case (phase_ff)
         PH_START: begin
            if (is_digit) begin
               t_phase = PH_LOW;
               ph_a    = PH_LOW;
            end else begin
               char_err = 1'b1;
            end
         end
         PH_LOW: begin
            if (is_dash) begin
               ph_a = PH_DASH;
            end else if (is_comma) begin
               ph_a = PH_START;
            end else if (!is_digit) begin
               char_err = 1'b1;
            end
         end
         PH_DASH: begin
            if (is_digit) begin
               t_phase = PH_HIGH;
               ph_a    = PH_HIGH;
            end else begin
               char_err = 1'b1;
            end
         end
         PH_HIGH: begin
            if (is_comma) begin
               ph_a = PH_START;
            end else if (!is_digit) begin
               char_err = 1'b1;
            end
         end
         default: char_err = 1'b1;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (last) begin
            phase_in = PH_START;
         end else if (!err_ff && !char_err) begin
            phase_in = ph_a;
         end
      end
   end

   // Element arithmetic, commit and the result.
   always_comb begin
      t_first  = first_ff;
      t_second = second_ff;
      if (is_digit && ((phase_ff == PH_START) || (phase_ff == PH_LOW))) begin
         t_first = add_digit(first_ff, d);
      end
      if (is_digit && ((phase_ff == PH_DASH) || (phase_ff == PH_HIGH))) begin
         t_second = add_digit(second_ff, d);
      end

      commit_req = !err_ff && !char_err &&
                   (is_comma || (last && ((ph_a == PH_LOW) || (ph_a == PH_HIGH))));
      end_err    = !err_ff && !char_err && last &&
                   ((ph_a == PH_START) || (ph_a == PH_DASH));
      single     = (t_phase == PH_LOW);
      lo         = t_first;
      hi         = single ? t_first : t_second;
      commit_bad = (lo >= lim) || (hi >= lim) || (hi < lo);

      ones  = '1;
      hi_p1 = {1'b0, hi} + 1'b1;
      span  = (ones << lo) & ~(ones << hi_p1);

      err_total  = err_ff || char_err || (commit_req && commit_bad) || end_err;
      mask_total = (commit_req && !commit_bad) ? (mask_ff | span) : mask_ff;

      first_in  = first_ff;
      second_in = second_ff;
      err_in    = err_ff;
      mask_in   = mask_ff;
      if (step) begin
         if (last) begin
            first_in  = '0;
            second_in = '0;
            err_in    = 1'b0;
            mask_in   = '0;
         end else if (!err_ff) begin
            first_in  = is_comma ? '0 : t_first;
            second_in = is_comma ? '0 : t_second;
            err_in    = err_total;
            mask_in   = mask_total;
         end
      end

      result.list_ok    = !err_total;
      result.entry_mask = err_total ? '0 : MASK_W'(mask_total);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         first_ff  <= '0;
         second_ff <= '0;
         err_ff    <= 1'b0;
         mask_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         err_ff    <= err_in;
         mask_ff   <= mask_in;
      end
   end

   `CRLP_ASSERT(a_list_clears, clock, reset, (step && last) |=> (phase_ff == PH_START && mask_ff == '0 && !err_ff), "state not cleared after the last character")
   `CRLP_ASSERT(a_err_sticky, clock, reset, (err_ff && !(step && last)) |=> err_ff, "error flag dropped within a list")
   `CRLP_ASSERT(a_nums_in_range, clock, reset, (phase_ff == PH_START) |-> (first_ff == '0 && second_ff == '0), "running numbers not cleared at element start")

endmodule

>>> rtl/cpu_range_list_parser.sv
// A result is registered: the last character of a list is accepted into the input register,
// then passes the parse logic into the result register.
// Throughput: one character per cycle while the input is not stalled; the parse state updates once per character.
// A waiting result stalls the input only when the next character also ends a list.
// Synchronous active-high reset clears the parse state and sets entry_count to 64.
`include "cpu_range_list_parser_defines.svh"

module cpu_range_list_parser #(
   parameter int MAX_ENTRIES = crlp_pkg::DEF_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [crlp_pkg::CHAR_W-1:0]       req_char_in,
   input  logic                              req_is_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_list_ok,
   output logic [crlp_pkg::MASK_W-1:0]       rsp_entry_mask,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [crlp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [crlp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [crlp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import crlp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   step_type          in_data_ff, in_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;
   result_type        result;
   logic [NUM_W-1:0]  entry_count;
   logic              out_free, step;

   crlp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .entry_count (entry_count)
   );

   crlp_parse #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_parse (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .step_data   (in_data_ff),
      .entry_count (entry_count),
      .result      (result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && (!in_data_ff.is_last || out_free);
   assign req_stall = in_valid_ff && !step;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (!req_stall) begin
         in_valid_in        = req_valid;
         in_data_in.char_in = req_char_in;
         in_data_in.is_last = req_is_last;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (step && in_data_ff.is_last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_list_ok    = rsp_data_ff.list_ok;
   assign rsp_entry_mask = rsp_data_ff.entry_mask;

   `CRLP_ASSERT(a_last_gives_result, clock, reset, (step && in_data_ff.is_last) |=> rsp_valid_ff, "last character produced no result")
   `CRLP_ASSERT(a_fail_mask_zero, clock, reset, (rsp_valid_ff && !rsp_data_ff.list_ok) |-> (rsp_data_ff.entry_mask == '0), "failed list carries a non-zero mask")
   `CRLP_ASSERT(a_blocked_last_stalls, clock, reset, (in_valid_ff && in_data_ff.is_last && rsp_valid_ff && rsp_stall) |-> req_stall, "list end accepted while the result register is full")

endmodule

>>> tb/cpu_range_list_parser_checker.sv
`timescale 1ns / 100ps

module cpu_range_list_parser_checker
   import crlp_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [CHAR_W-1:0]     req_char_in,
   input  logic                  req_is_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_list_ok,
   input  logic [MASK_W-1:0]     rsp_entry_mask,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    pending,
   output int                    lists_seen,
   output int                    lists_ok
);

   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

   result_type       expected_lists[$];
   phase_type        phase;
   logic [NUM_W-1:0] low_num;
   logic [NUM_W-1:0] high_num;
   logic [NUM_W-1:0] entry_count;
   logic             list_bad;
   logic [MASK_W-1:0] mask_acc;

   function automatic logic [NUM_W-1:0] push_digit(input logic [NUM_W-1:0] acc,
                                                   input logic [CHAR_W-1:0] c);
      int v;
      v = int'(acc) * 10 + int'(c - CH_ZERO);
      return (v > int'(NUM_SAT)) ? NUM_SAT : NUM_W'(v);
   endfunction

   function automatic void clear_list();
      phase    = PH_START;
      low_num  = '0;
      high_num = '0;
      list_bad = 1'b0;
      mask_acc = '0;
   endfunction

   function automatic void close_element(input bit single);
      int lim;
      int lo;
      int hi;
      int i;
      lim = (int'(entry_count) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_count);
      lo  = int'(low_num);
      hi  = single ? int'(low_num) : int'(high_num);
      if (lo >= lim || hi >= lim || hi < lo) begin
         list_bad = 1'b1;
      end else begin
         for (i = lo; i <= hi; i++) mask_acc[i] = 1'b1;
      end
   endfunction

   function automatic void take_char(input logic [CHAR_W-1:0] c);
      bit digit;
      digit = (c >= CH_ZERO) && (c <= CH_NINE);
      case (phase)
         PH_START: begin
            if (digit) begin
               low_num = push_digit(low_num, c);
               phase   = PH_LOW;
            end else begin
               list_bad = 1'b1;
            end
         end
         PH_LOW: begin
            if (digit) begin
               low_num = push_digit(low_num, c);
            end else if (c == CH_DASH) begin
               phase = PH_DASH;
            end else if (c == CH_COMMA) begin
               close_element(1'b1);
               low_num  = '0;
               high_num = '0;
               phase    = PH_START;
            end else begin
               list_bad = 1'b1;
            end
         end
         PH_DASH: begin
            if (digit) begin
               high_num = push_digit(high_num, c);
               phase    = PH_HIGH;
            end else begin
               list_bad = 1'b1;
            end
         end
         default: begin
            if (digit) begin
               high_num = push_digit(high_num, c);
            end else if (c == CH_COMMA) begin
               close_element(1'b0);
               low_num  = '0;
               high_num = '0;
               phase    = PH_START;
            end else begin
               list_bad = 1'b1;
            end
         end
      endcase
   endfunction

   task automatic report(input string what, input logic [MASK_W:0] want_v,
                         input logic [MASK_W:0] got_v);
      failures++;
      if (failures <= 10) $display("%s: expected %h, got %h", what, want_v, got_v);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_list();
         entry_count = ENTRY_COUNT_RST;
         expected_lists.delete();
         failures   = 0;
         lists_seen = 0;
         lists_ok   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == COUNT_ADDR) begin
            if (csr_pwrite) begin
               entry_count = csr_pwdata[NUM_W-1:0];
            end else if (csr_prdata !== CSR_DATA_W'(entry_count)) begin
               report("entry_count readback", (MASK_W+1)'(entry_count),
                      (MASK_W+1)'(csr_prdata));
            end
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_lists.size() == 0) begin
               report("result with nothing outstanding", '0, {rsp_list_ok, rsp_entry_mask});
            end else begin
               want = expected_lists.pop_front();
               if (rsp_list_ok !== want.list_ok)
                  report("list_ok", (MASK_W+1)'(want.list_ok), (MASK_W+1)'(rsp_list_ok));
               if (rsp_entry_mask !== want.entry_mask)
                  report("entry_mask", (MASK_W+1)'(want.entry_mask),
                         (MASK_W+1)'(rsp_entry_mask));
            end
         end

         if (req_valid && !req_stall) begin
            if (!list_bad) take_char(req_char_in);
            if (req_is_last) begin
               if (!list_bad) begin
                  case (phase)
                     PH_LOW:  close_element(1'b1);
                     PH_HIGH: close_element(1'b0);
                     default: list_bad = 1'b1;
                  endcase
               end
               want.list_ok    = !list_bad;
               want.entry_mask = list_bad ? '0 : mask_acc;
               expected_lists.push_back(want);
               lists_seen++;
               if (!list_bad) lists_ok++;
               clear_list();
            end
         end
      end
      pending = expected_lists.size();
   end

endmodule

>>> tb/cpu_range_list_parser_test.sv
`timescale 1ns / 100ps

module cpu_range_list_parser_test;
   import crlp_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 215;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 3000;
   localparam logic [CSR_ADDR_W-1:0] COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_char_in = '0;
   logic                  req_is_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_list_ok;
   logic [MASK_W-1:0]     rsp_entry_mask;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int pending;
   int lists_seen;
   int lists_ok;

   int  chars_sent = 0;
   int  settings_used = 0;
   int  entry_limit = DEF_ENTRIES;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;
   bit  hold_ask = 1'b0;
   bit  hold_used = 1'b0;
   logic [CHAR_W-1:0] text[$];

   always #5 clock = ~clock;

   cpu_range_list_parser u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_list_ok    (rsp_list_ok),
      .rsp_entry_mask (rsp_entry_mask),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   cpu_range_list_parser_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_list_ok    (rsp_list_ok),
      .rsp_entry_mask (rsp_entry_mask),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .failures       (failures),
      .pending        (pending),
      .lists_seen     (lists_seen),
      .lists_ok       (lists_ok)
   );

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("cpu_range_list_parser regression: fail");
         $finish;
      end
   end

   // The result side: random back-pressure bursts, and one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_ask && !hold_used) begin
            hold_used = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] c, input bit last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      req_is_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   // Stops driving requests and waits until every expected transaction has come back.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input bit write, input logic [NUM_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= COUNT_ADDR;
      csr_pwdata  <= {(CSR_DATA_W - NUM_W)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_count(input int value);
      csr_access(1'b1, NUM_W'(value));
      csr_access(1'b0, NUM_W'(value));
      entry_limit = (value > DEF_ENTRIES) ? DEF_ENTRIES : value;
      settings_used++;
   endtask

   task automatic put_number(input int n);
      if ($urandom_range(0, 7) == 0) text.push_back(CH_ZERO);
      if (n >= 100) text.push_back(CH_ZERO + CHAR_W'(n / 100));
      if (n >= 10) text.push_back(CH_ZERO + CHAR_W'((n / 10) % 10));
      text.push_back(CH_ZERO + CHAR_W'(n % 10));
   endtask

   function automatic int pick_number(input int lo, input int span);
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return span - 1;
         default: return $urandom_range(lo, span - 1);
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] pick_symbol();
      string symbols;
      symbols = "0123456789,-";
      return symbols[$urandom_range(0, 11)];
   endfunction

   // Mostly well-formed lists with random content; some are then broken, a few are noise.
   task automatic build_list(input int lim);
      int kind;
      int elems;
      int span;
      int e;
      int lo;
      int hi;
      int n;
      text.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1)) text.push_back(CHAR_W'($urandom_range(0, 255)));
            else text.push_back(pick_symbol());
         end
         return;
      end
      span  = (lim > 0) ? lim : 10;
      elems = $urandom_range(1, 4);
      for (e = 0; e < elems; e++) begin
         if (e > 0) text.push_back(CH_COMMA);
         lo = pick_number(0, span);
         put_number(lo);
         if ($urandom_range(0, 1)) begin
            hi = pick_number(lo, span);
            text.push_back(CH_DASH);
            put_number(hi);
         end
      end
      if (kind >= 7) begin
         case ($urandom_range(0, 7))
            0: text[$urandom_range(0, text.size() - 1)] = CHAR_W'($urandom_range(0, 255));
            1: text.push_front(CH_COMMA);
            2: text.push_back(CH_COMMA);
            3: text.push_back(CH_DASH);
            4: begin
               n = $urandom_range(0, 62);
               text.push_back(CH_COMMA);
               put_number(n + 1);
               text.push_back(CH_DASH);
               put_number(n);
            end
            5: begin
               text.push_back(CH_COMMA);
               put_number($urandom_range(lim, 127));
            end
            6: begin
               text.push_back(CH_COMMA);
               repeat ($urandom_range(4, 6)) text.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
            end
            default: text.insert($urandom_range(0, text.size() - 1), 8'h00);
         endcase
      end
   endtask

   initial begin
      int setting[PHASES];
      int p;
      int first_item;
      setting = '{1, 0, 127, 64, 65, 1, 0, 64};
      setting[5] = $urandom_range(1, 64);
      setting[6] = $urandom_range(0, 127);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      program_count(int'(ENTRY_COUNT_RST));

      send_string("0-63");
      send_string("63,0");
      send_string("7-3");
      send_string(",1");
      send_string("1-");
      send_string("64");
      send_string("999");
      send_string("5");
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      settle();

      for (p = 0; p < PHASES; p++) begin
         calm = (p == PHASES - 1);
         program_count(setting[p]);
         first_item = chars_sent;
         if (p == 2) begin
            hold_ask = 1'b1;
            repeat (40) send_char(CH_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b1);
         end
         while (chars_sent - first_item < PHASE_ITEMS) begin
            build_list(entry_limit);
            send_text();
         end
         settle();
      end

      $display("Covered %0d characters in %0d lists (%0d well formed, %0d rejected),",
               chars_sent, lists_seen, lists_ok, lists_seen - lists_ok);
      $display("over %0d entry_count settings from 0 to 127, with random and long back-pressure.",
               settings_used);
      if (failures == 0 && pending == 0) begin
         $display("cpu_range_list_parser regression: pass");
      end else begin
         $display("cpu_range_list_parser regression: fail");
      end
      $finish;
   end

endmodule
